[sv/m3i_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 matrix inverse
// Lane count, cofactor routing tables and pipeline stage numbering.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int NLANES = 9;

    // Pipeline stage numbers; the divider steps start at ST_DIV0
    localparam int ST_PROD = 0;
    localparam int ST_COF  = 1;
    localparam int ST_PART = 2;
    localparam int ST_TERM = 3;
    localparam int ST_SUM  = 4;
    localparam int ST_ABS  = 5;
    localparam int ST_NUM  = 6;
    localparam int ST_DIV0 = 7;

    // Element index is row*3+col. Lane k computes adjugate element k (row*3+col)
    // as p*q - s*t, negated where COF_NEG is set.
    localparam int COF_IDX [NLANES][4] = '{
        '{4, 8, 5, 7},
        '{1, 8, 2, 7},
        '{1, 5, 2, 4},
        '{3, 8, 5, 6},
        '{0, 8, 2, 6},
        '{0, 5, 2, 3},
        '{3, 7, 4, 6},
        '{0, 7, 1, 6},
        '{0, 4, 1, 3}
    };
    localparam bit [NLANES-1:0] COF_NEG = 9'b010101010;

endpackage

`default_nettype wire

[sv/m3i_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_in_if: matrix request channel
// Valid/ready handshake carrying nine signed fixed-point elements.
// ----------------------------------------------------------------------------
interface m3i_in_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_r0c0;
    logic signed [W-1:0] in_r1c0;
    logic signed [W-1:0] in_r2c0;
    logic signed [W-1:0] in_r0c1;
    logic signed [W-1:0] in_r1c1;
    logic signed [W-1:0] in_r2c1;
    logic signed [W-1:0] in_r0c2;
    logic signed [W-1:0] in_r1c2;
    logic signed [W-1:0] in_r2c2;

    modport source (output valid, in_r0c0, in_r1c0, in_r2c0, in_r0c1, in_r1c1,
                    in_r2c1, in_r0c2, in_r1c2, in_r2c2, input ready);
    modport sink   (input valid, in_r0c0, in_r1c0, in_r2c0, in_r0c1, in_r1c1,
                    in_r2c1, in_r0c2, in_r1c2, in_r2c2, output ready);
endinterface

`default_nettype wire

[sv/m3i_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_out_if: inverse result channel
// Valid/ready handshake carrying nine inverse elements and two flags.
// ----------------------------------------------------------------------------
interface m3i_out_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_r0c0;
    logic signed [W-1:0] out_r1c0;
    logic signed [W-1:0] out_r2c0;
    logic signed [W-1:0] out_r0c1;
    logic signed [W-1:0] out_r1c1;
    logic signed [W-1:0] out_r2c1;
    logic signed [W-1:0] out_r0c2;
    logic signed [W-1:0] out_r1c2;
    logic signed [W-1:0] out_r2c2;
    logic                singular;
    logic                overflow;

    modport source (output valid, out_r0c0, out_r1c0, out_r2c0, out_r0c1, out_r1c1,
                    out_r2c1, out_r0c2, out_r1c2, out_r2c2, singular, overflow,
                    input ready);
    modport sink   (input valid, out_r0c0, out_r1c0, out_r2c0, out_r0c1, out_r1c1,
                    out_r2c1, out_r0c2, out_r1c2, out_r2c2, singular, overflow,
                    output ready);
endinterface

`default_nettype wire

[sv/matrix3_inverse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 fixed-point matrix inverse
// Adjugate over determinant, truncated toward zero and saturated to the word;
// a singular matrix returns the identity.
// ----------------------------------------------------------------------------
//  port  dir  payload
//  mat   in   in_r0c0 .. in_r2c2, signed Q(W-F).F
//  res   out  out_r0c0 .. out_r2c2, singular, overflow
//
//  Seven stages of products, cofactors and determinant, W divider stages (one
//  quotient bit each) and one output stage. One matrix enters every cycle
//  unless a stalled result has filled the pipeline; nine lanes each own one
//  cofactor divider. Reset clears the stage valid bits only.
//  A stalled result stalls only up to the first empty stage; bubbles collapse.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    m3i_in_if.sink    mat,
    m3i_out_if.source res
);
    import m3i_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NS = W + ST_DIV0 + 1;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_VAL = (F < W - 1) ? (W'(1) << F) : MAX_POS;
    localparam bit           ONE_OVF = (F >= W - 1);

    logic [NS-1:0]        valid_reg;
    logic [NS-1:0]        en;
    logic signed [W-1:0]  elem [9];
    logic signed [CW-1:0] cof  [NLANES];
    logic [W-1:0]         quo  [NLANES];
    logic                 big  [NLANES];
    logic                 neg  [NLANES];
    logic                 zero [NLANES];
    logic [DW-1:0]        dmag;
    logic                 dneg, dzero;
    logic [W-1:0]         res_next [NLANES];
    logic [W-1:0]         res_reg  [NLANES];
    logic                 ovf_next, sing_reg, ovf_reg;

    // Flatten the request as row*3+col
    assign elem[0] = mat.in_r0c0;
    assign elem[1] = mat.in_r0c1;
    assign elem[2] = mat.in_r0c2;
    assign elem[3] = mat.in_r1c0;
    assign elem[4] = mat.in_r1c1;
    assign elem[5] = mat.in_r1c2;
    assign elem[6] = mat.in_r2c0;
    assign elem[7] = mat.in_r2c1;
    assign elem[8] = mat.in_r2c2;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || res.ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign mat.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= mat.valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // Cofactor lanes
    for (genvar k = 0; k < NLANES; k++) begin : g_lane
        m3i_lane #(.W(W), .F(F), .NEG(COF_NEG[k])) u_lane (
            .clk   (clk),
            .en    (en),
            .p     (elem[COF_IDX[k][0]]),
            .q     (elem[COF_IDX[k][1]]),
            .s     (elem[COF_IDX[k][2]]),
            .t     (elem[COF_IDX[k][3]]),
            .dmag  (dmag),
            .dneg  (dneg),
            .dzero (dzero),
            .cof   (cof[k]),
            .quo   (quo[k]),
            .big   (big[k]),
            .neg   (neg[k]),
            .zero  (zero[k])
        );
    end

    // Determinant from row 0 and the first adjugate column
    m3i_det #(.W(W)) u_det (
        .clk   (clk),
        .en    (en),
        .a0    (elem[0]),
        .a1    (elem[1]),
        .a2    (elem[2]),
        .c0    (cof[0]),
        .c1    (cof[3]),
        .c2    (cof[6]),
        .dmag  (dmag),
        .dneg  (dneg),
        .dzero (dzero)
    );

    // Merge: saturate each lane, combine flags, drop to identity when singular
    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] mag;
        logic         sat;
        ovf_next = 1'b0;
        for (int k = 0; k < NLANES; k++)
        begin
            lim = neg[k] ? MIN_MAG : MAX_POS;
            sat = big[k] || (quo[k] > lim);
            mag = sat ? lim : quo[k];
            if (zero[0])
                res_next[k] = (k % 4 == 0) ? ONE_VAL : '0;
            else
            begin
                res_next[k] = neg[k] ? W'(-mag) : mag;
                ovf_next    = ovf_next | sat;
            end
        end
        if (zero[0])
            ovf_next = ONE_OVF;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            res_reg  <= res_next;
            sing_reg <= zero[0];
            ovf_reg  <= ovf_next;
        end
    end

    assign res.valid    = valid_reg[NS-1];
    assign res.out_r0c0 = res_reg[0];
    assign res.out_r0c1 = res_reg[1];
    assign res.out_r0c2 = res_reg[2];
    assign res.out_r1c0 = res_reg[3];
    assign res.out_r1c1 = res_reg[4];
    assign res.out_r1c2 = res_reg[5];
    assign res.out_r2c0 = res_reg[6];
    assign res.out_r2c1 = res_reg[7];
    assign res.out_r2c2 = res_reg[8];
    assign res.singular = sing_reg;
    assign res.overflow = ovf_reg;

endmodule

`default_nettype wire

[sv/m3i_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_lane: one cofactor and one quotient
// Forms p*q - s*t (negated when NEG) at full width, scales it by 2^(2F) and divides its magnitude
// by the determinant magnitude, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module m3i_lane #(
    parameter int W   = 32,
    parameter int F   = 16,
    parameter bit NEG = 1'b0,
    localparam int NS = W + m3i_pkg::ST_DIV0 + 1,
    localparam int CW = 2 * W + 1,
    localparam int DW = 3 * W + 3
) (
    input  wire logic                 clk,
    input  wire logic [NS-1:0]        en,
    input  wire logic signed [W-1:0]  p,
    input  wire logic signed [W-1:0]  q,
    input  wire logic signed [W-1:0]  s,
    input  wire logic signed [W-1:0]  t,
    input  wire logic [DW-1:0]        dmag,
    input  wire logic                 dneg,
    input  wire logic                 dzero,
    output logic signed [CW-1:0]      cof,
    output logic [W-1:0]              quo,
    output logic                      big,
    output logic                      neg,
    output logic                      zero
);
    import m3i_pkg::*;

    localparam int NW = CW + 2 * F;
    localparam int RW = (NW > DW + W) ? NW : DW + W;

    logic signed [2*W-1:0] px_reg, py_reg;
    logic signed [CW-1:0]  cof_reg;
    logic signed [CW-1:0]  cpipe_reg [3];
    logic [CW-1:0]         cmag_reg;
    logic                  csign_reg;
    logic [RW-1:0]         rem_reg   [W+1];
    logic [W-1:0]          quo_reg   [W+1];
    logic [DW-1:0]         dm_reg    [W+1];
    logic                  big_reg   [W+1];
    logic                  neg_reg   [W+1];
    logic                  zero_reg  [W+1];
    logic [RW-1:0]         num_next;

    // Multiply the two cofactor products
    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            px_reg <= p * q;
            py_reg <= s * t;
        end
    end

    // Subtract at full width
    always_ff @(posedge clk)
    begin
        if (en[ST_COF])
        begin
            if (NEG)
                cof_reg <= CW'(py_reg) - CW'(px_reg);
            else
                cof_reg <= CW'(px_reg) - CW'(py_reg);
        end
    end

    assign cof = cof_reg;

    // Hold the cofactor while the determinant is summed
    always_ff @(posedge clk)
    begin
        if (en[ST_PART])
            cpipe_reg[0] <= cof_reg;
        if (en[ST_TERM])
            cpipe_reg[1] <= cpipe_reg[0];
        if (en[ST_SUM])
            cpipe_reg[2] <= cpipe_reg[1];
        if (en[ST_ABS])
        begin
            csign_reg <= cpipe_reg[2][CW-1];
            cmag_reg  <= cpipe_reg[2][CW-1] ? CW'(-cpipe_reg[2]) : cpipe_reg[2];
        end
    end

    // Scale the numerator and check the quotient against the word
    assign num_next = RW'(cmag_reg) << (2 * F);

    always_ff @(posedge clk)
    begin
        if (en[ST_NUM])
        begin
            rem_reg[0]  <= num_next;
            quo_reg[0]  <= '0;
            dm_reg[0]   <= dmag;
            big_reg[0]  <= num_next >= (RW'(dmag) << W);
            neg_reg[0]  <= csign_reg ^ dneg;
            zero_reg[0] <= dzero;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar j = 0; j < W; j++) begin : g_div
        logic [RW-1:0] trial;
        logic          take;

        assign trial = RW'(dm_reg[j]) << (W - 1 - j);
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0 + j])
            begin
                rem_reg[j+1]  <= take ? rem_reg[j] - trial : rem_reg[j];
                quo_reg[j+1]  <= quo_reg[j] | (W'(take) << (W - 1 - j));
                dm_reg[j+1]   <= dm_reg[j];
                big_reg[j+1]  <= big_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    assign quo  = quo_reg[W];
    assign big  = big_reg[W];
    assign neg  = neg_reg[W];
    assign zero = zero_reg[W];

endmodule

`default_nettype wire

[sv/m3i_det.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_det: determinant unit
// Expands along row 0 using three lane cofactors; each product is split into
// two partial products no wider than W by W+1 bits.
// ----------------------------------------------------------------------------
module m3i_det #(
    parameter int W   = 32,
    localparam int NS = W + m3i_pkg::ST_DIV0 + 1,
    localparam int CW = 2 * W + 1,
    localparam int DW = 3 * W + 3
) (
    input  wire logic                 clk,
    input  wire logic [NS-1:0]        en,
    input  wire logic signed [W-1:0]  a0,
    input  wire logic signed [W-1:0]  a1,
    input  wire logic signed [W-1:0]  a2,
    input  wire logic signed [CW-1:0] c0,
    input  wire logic signed [CW-1:0] c1,
    input  wire logic signed [CW-1:0] c2,
    output logic [DW-1:0]             dmag,
    output logic                      dneg,
    output logic                      dzero
);
    import m3i_pkg::*;

    logic signed [W-1:0]  a0_reg [3];
    logic signed [W-1:0]  a1_reg [3];
    logic signed [CW-1:0] c_in   [3];
    logic signed [CW-1:0] pl_reg [3];
    logic signed [CW-1:0] ph_reg [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] sum_reg;
    logic [DW-1:0]        dmag_reg;
    logic                 dneg_reg, dzero_reg;

    assign c_in[0] = c0;
    assign c_in[1] = c1;
    assign c_in[2] = c2;

    // Hold the row-0 elements until the cofactors arrive
    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            a0_reg[0] <= a0;
            a0_reg[1] <= a1;
            a0_reg[2] <= a2;
        end
        if (en[ST_COF])
            a1_reg <= a0_reg;
    end

    // Split each cofactor into a low unsigned word and a high signed part
    for (genvar k = 0; k < 3; k++) begin : g_term
        always_ff @(posedge clk)
        begin
            if (en[ST_PART])
            begin
                pl_reg[k] <= a1_reg[k] * $signed({1'b0, c_in[k][W-1:0]});
                ph_reg[k] <= a1_reg[k] * $signed(c_in[k][CW-1:W]);
            end
            if (en[ST_TERM])
                term_reg[k] <= (DW'(ph_reg[k]) <<< W) + DW'(pl_reg[k]);
        end
    end

    // Sum the terms, then take sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
            sum_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        if (en[ST_ABS])
        begin
            dneg_reg  <= sum_reg[DW-1];
            dzero_reg <= sum_reg == '0;
            dmag_reg  <= sum_reg[DW-1] ? DW'(-sum_reg) : DW'(sum_reg);
        end
    end

    assign dmag  = dmag_reg;
    assign dneg  = dneg_reg;
    assign dzero = dzero_reg;

endmodule

`default_nettype wire

[sim/matrix3_inverse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_checker: result predictor and scoreboard
// Watches the matrix and result channels, computes the expected inverse of
// every accepted matrix and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    m3i_in_if    mat,
    m3i_out_if   res,
    output int   fail_count,
    output int   pending
);

    localparam int WIDE = 4 * WORD_BITS + 2 * FRAC_BITS + 8;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct {
        word_t elem [9];
        logic  singular;
        logic  overflow;
    } inverse_t;

    inverse_t inverse_q [$];

    // Clamp a full-width quotient to the word and note saturation
    function automatic word_t clamp_word(input wide_t v, inout logic ovf);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
        lo = -(wide_t'(1) <<< (WORD_BITS - 1));
        if (v > hi)
        begin
            ovf = 1'b1;
            return word_t'(hi);
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return word_t'(lo);
        end
        return word_t'(v);
    endfunction

    // Compute adjugate over determinant; elements indexed row*3+col
    function automatic inverse_t invert_matrix(input word_t m [9]);
        inverse_t r;
        wide_t a [9];
        wide_t adj [9];
        wide_t det;
        wide_t q;
        wide_t num;
        wide_t mag;
        logic ovf;
        ovf = 1'b0;
        for (int i = 0; i < 9; i++)
            a[i] = wide_t'(m[i]);
        adj[0] = a[4] * a[8] - a[5] * a[7];
        adj[1] = a[2] * a[7] - a[1] * a[8];
        adj[2] = a[1] * a[5] - a[2] * a[4];
        adj[3] = a[5] * a[6] - a[3] * a[8];
        adj[4] = a[0] * a[8] - a[2] * a[6];
        adj[5] = a[2] * a[3] - a[0] * a[5];
        adj[6] = a[3] * a[7] - a[4] * a[6];
        adj[7] = a[1] * a[6] - a[0] * a[7];
        adj[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        r.singular = (det == 0);
        if (r.singular)
        begin
            for (int i = 0; i < 9; i++)
                r.elem[i] = (i % 4 == 0) ?
                    clamp_word(wide_t'(1) <<< FRAC_BITS, ovf) : '0;
        end
        else
        begin
            mag = (det < 0) ? -det : det;
            for (int i = 0; i < 9; i++)
            begin
                num = (adj[i] < 0) ? -adj[i] : adj[i];
                q = (num <<< (2 * FRAC_BITS)) / mag;
                if ((adj[i] < 0) != (det < 0))
                    q = -q;
                r.elem[i] = clamp_word(q, ovf);
            end
        end
        r.overflow = ovf;
        return r;
    endfunction

    // Predict on every accepted request, compare on every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        word_t m [9];
        word_t got [9];
        inverse_t want;
        int errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (mat.valid && mat.ready)
            begin
                m = '{mat.in_r0c0, mat.in_r0c1, mat.in_r0c2,
                      mat.in_r1c0, mat.in_r1c1, mat.in_r1c2,
                      mat.in_r2c0, mat.in_r2c1, mat.in_r2c2};
                inverse_q.push_back(invert_matrix(m));
            end
            if (res.valid && res.ready)
            begin
                got = '{res.out_r0c0, res.out_r0c1, res.out_r0c2,
                        res.out_r1c0, res.out_r1c1, res.out_r1c2,
                        res.out_r2c0, res.out_r2c1, res.out_r2c2};
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected result", $time);
                    errs++;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want.elem[i])
                        begin
                            $display("%0t: r%0dc%0d expected %h actual %h", $time,
                                     i / 3, i % 3, want.elem[i], got[i]);
                            errs++;
                        end
                    if (res.singular !== want.singular || res.overflow !== want.overflow)
                    begin
                        $display("%0t: flags expected s%b o%b actual s%b o%b", $time,
                                 want.singular, want.overflow, res.singular,
                                 res.overflow);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= inverse_q.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: matrix3_inverse top-level test
// Drives directed and random matrices in bursts with a stalling receiver and
// reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int W = 32;
    localparam int F = 16;
    localparam int RANDOM_COUNT = 1700;
    localparam int IDLE_LIMIT = 5000;

    typedef logic signed [W-1:0] word_t;

    logic clk;
    logic rst_n;
    int fail_count;
    int pending;
    int idle_cycles;
    bit send_done;

    m3i_in_if  #(.W(W)) mat ();
    m3i_out_if #(.W(W)) res ();

    matrix3_inverse #(.WORD_BITS(W), .FRAC_BITS(F)) DUT (
        .clk(clk), .rst_n(rst_n), .mat(mat), .res(res));

    matrix3_inverse_checker #(.WORD_BITS(W), .FRAC_BITS(F)) checker_i (
        .clk(clk), .rst_n(rst_n), .mat(mat), .res(res),
        .fail_count(fail_count), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Pick an element: extremes, small Q16.16 values or full random
    function automatic word_t pick_element(input int mode);
        case (mode)
            0: return word_t'($urandom);
            1: return word_t'($signed($urandom_range(0, 8 << F)) - (4 << F));
            2: return word_t'($signed($urandom_range(0, 64)) - 32) <<< F;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return {1'b1, {(W-1){1'b0}}};
                    1: return {1'b0, {(W-1){1'b1}}};
                    2: return '0;
                    3: return word_t'(1 << F);
                    4: return word_t'(1);
                    default: return -word_t'(1);
                endcase
            end
        endcase
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_matrix(input word_t m [9]);
        mat.valid   <= 1'b1;
        mat.in_r0c0 <= m[0]; mat.in_r0c1 <= m[1]; mat.in_r0c2 <= m[2];
        mat.in_r1c0 <= m[3]; mat.in_r1c1 <= m[4]; mat.in_r1c2 <= m[5];
        mat.in_r2c0 <= m[6]; mat.in_r2c1 <= m[7]; mat.in_r2c2 <= m[8];
        @(posedge clk);
        while (!mat.ready)
            @(posedge clk);
    endtask

    task automatic send_directed(input int kind);
        word_t m [9];
        for (int i = 0; i < 9; i++)
            m[i] = '0;
        case (kind)
            0: for (int i = 0; i < 9; i += 4) m[i] = word_t'(1 << F);
            1: ;
            2: for (int i = 0; i < 9; i++) m[i] = {1'b1, {(W-1){1'b0}}};
            3: for (int i = 0; i < 9; i++) m[i] = {1'b0, {(W-1){1'b1}}};
            4: for (int i = 0; i < 9; i += 4) m[i] = word_t'(1);
            5: for (int i = 0; i < 9; i += 4) m[i] = {1'b1, {(W-1){1'b0}}};
            6: for (int i = 0; i < 9; i += 4) m[i] = -word_t'(2 << F);
            7: begin m[0] = 1; m[4] = {1'b0, {(W-1){1'b1}}}; m[8] = -1; end
            8: begin m[2] = word_t'(1 << F); m[4] = -word_t'(1 << F);
                     m[6] = word_t'(3 << F); end
            9: for (int i = 0; i < 9; i++) m[i] = word_t'((i + 1) << F);
            default: for (int i = 0; i < 9; i++) m[i] = pick_element(3);
        endcase
        send_matrix(m);
    endtask

    // Sender: directed cases, then random bursts with gaps
    initial
    begin
        word_t m [9];
        int burst;
        int mode;
        int gap;
        mat.valid <= 1'b0;
        mat.in_r0c0 <= '0; mat.in_r0c1 <= '0; mat.in_r0c2 <= '0;
        mat.in_r1c0 <= '0; mat.in_r1c1 <= '0; mat.in_r1c2 <= '0;
        mat.in_r2c0 <= '0; mat.in_r2c1 <= '0; mat.in_r2c2 <= '0;
        send_done = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 20; k++)
            send_directed(k);
        for (int n = 0; n < RANDOM_COUNT; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++)
            begin
                mode = $urandom_range(0, 3);
                for (int i = 0; i < 9; i++)
                    m[i] = pick_element($urandom_range(0, 9) == 0 ? 3 : mode);
                if ($urandom_range(0, 9) == 0)
                    for (int i = 0; i < 3; i++)
                        m[6 + i] = m[3 + i];
                send_matrix(m);
                n++;
            end
            // Drop valid only when a gap follows
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                mat.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        mat.valid <= 1'b0;
        send_done = 1'b1;
    end

    // Receiver: stall pattern plus one long hold-off while requests pile up
    initial
    begin
        int cyc;
        res.ready <= 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= 300 && cyc < 500)
                res.ready <= 1'b0;
            else if ((cyc / 64) % 3 == 0)
                res.ready <= 1'b1;
            else
                res.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog and verdict
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (!(send_done && pending == 0) && idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((mat.valid && mat.ready) || (res.valid && res.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
        end
        else
        begin
            repeat (2 * (W + 8)) @(posedge clk);
            if (fail_count == 0 && pending == 0)
                $display("testbench passed");
            else
                $display("testbench failed");
        end
        $finish;
    end

endmodule
